### hdl/mspb_pkg.sv
// Package for the masked sprite blit page buffer.
// Item codes, draw modes, control structs and the pixel combine function.
// Depends on nothing.
`timescale 1ns / 1ps

package mspb_pkg;

  localparam int SCREEN_COLUMNS_DEF = 128;
  localparam int SCREEN_ROWS_DEF    = 64;
  localparam int PIX_PER_PAGE       = 8;
  localparam int HOST_ADDR_W        = 10;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_BEGIN,
    FUNC_SPRITE,
    FUNC_READ,
    FUNC_WRITE
  } mspb_func_t;

  typedef enum logic [1:0] {
    MODE_OVER,
    MODE_OR,
    MODE_ERASE,
    MODE_MASK
  } mspb_mode_t;

  typedef struct packed {
    logic begin_load;
    logic byte_load;
    logic rd_host;
    logic wr_host;
    logic rd_lo;
    logic wr_lo;
    logic rd_hi;
    logic wr_hi;
    logic clr_wr;
    logic out_load;
  } mspb_cmd_t;

  typedef struct packed {
    logic active;
    logic lo_ok;
    logic hi_ok;
    logic clr_last;
  } mspb_stat_t;

  function automatic logic [7:0] mspb_apply(mspb_mode_t mode, logic [7:0] d,
                                            logic [7:0] img, logic [7:0] msk);
    logic [7:0] res;
    case (mode)
      MODE_OVER:  res = (d & ~msk) | img;
      MODE_OR:    res = d | img;
      MODE_ERASE: res = d & ~img;
      MODE_MASK:  res = (d & ~msk) | img;
      default:    res = d;
    endcase
    return res;
  endfunction

endpackage

### hdl/mspb_if.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on mspb_pkg.
`timescale 1ns / 1ps

interface mspb_in_if import mspb_pkg::*; ();
  logic              valid;
  logic              ready;
  mspb_func_t        func;
  logic signed [9:0] pos_x;
  logic signed [9:0] pos_y;
  logic [7:0]        sprite_width;
  logic [7:0]        sprite_height;
  mspb_mode_t        blend_mode;
  logic [7:0]        image_byte;
  logic [7:0]        mask_byte;
  logic [HOST_ADDR_W-1:0] store_addr;
  logic [7:0]        store_data;

  modport source (output valid, func, pos_x, pos_y, sprite_width, sprite_height,
                  blend_mode, image_byte, mask_byte, store_addr, store_data,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, sprite_width, sprite_height,
                blend_mode, image_byte, mask_byte, store_addr, store_data,
                output ready);
endinterface

interface mspb_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

### hdl/mspb_ram.sv
// Generic simple dual port RAM: one write port, one read port with
// registered, enabled read data. No dependencies.
`timescale 1ns / 1ps

module mspb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/mspb_ctrl.sv
// Controller state machine: sequences clear pass, host access and the
// read-modify-write of sprite bytes. Depends on mspb_pkg.
`timescale 1ns / 1ps

module mspb_ctrl import mspb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  mspb_func_t in_func,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  mspb_stat_t stat,
  output mspb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOST_RD,
    S_RD_LO,
    S_WR_LO,
    S_WR_HI
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign acc       = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          case (in_func)
            FUNC_BEGIN: cmd.begin_load = 1'b1;
            FUNC_SPRITE: begin
              if (stat.active) begin
                cmd.byte_load = 1'b1;
                state_nxt     = S_RD_LO;
              end
            end
            FUNC_READ: begin
              cmd.rd_host = 1'b1;
              state_nxt   = S_HOST_RD;
            end
            FUNC_WRITE: cmd.wr_host = 1'b1;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HOST_RD: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_WR_LO;
      end
      S_WR_LO: begin
        cmd.wr_lo = stat.lo_ok;
        cmd.rd_hi = stat.hi_ok;
        state_nxt = stat.hi_ok ? S_WR_HI : S_IDLE;
      end
      S_WR_HI: begin
        cmd.wr_hi = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/mspb_dpath.sv
// Datapath: blit registers, sprite counters, address and clip logic,
// pixel combine, result register and the frame store RAM.
// Depends on mspb_pkg and mspb_ram.
`timescale 1ns / 1ps

module mspb_dpath import mspb_pkg::*; #(
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mspb_cmd_t              cmd,
  output mspb_stat_t             stat,
  input  logic signed [9:0]      pos_x,
  input  logic signed [9:0]      pos_y,
  input  logic [7:0]             sprite_width,
  input  logic [7:0]             sprite_height,
  input  mspb_mode_t             blend_mode,
  input  logic [7:0]             image_byte,
  input  logic [7:0]             mask_byte,
  input  logic [HOST_ADDR_W-1:0] store_addr,
  input  logic [7:0]             store_data,
  output logic [7:0]             read_data
);

  localparam int PAGES       = SCREEN_ROWS / PIX_PER_PAGE;
  localparam int STORE_BYTES = SCREEN_COLUMNS * PAGES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PIDX_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CIDX_W      = $clog2(SCREEN_COLUMNS);
  localparam int CMP_W       = ((ADDR_W > HOST_ADDR_W) ? ADDR_W : HOST_ADDR_W) + 1;
  localparam logic [CMP_W-1:0]  STORE_LIM = CMP_W'(STORE_BYTES);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(STORE_BYTES - 1);
  localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);
  localparam logic signed [11:0] COLS12   = 12'(SCREEN_COLUMNS);
  localparam logic signed [11:0] ROWS12   = 12'(SCREEN_ROWS);
  localparam logic signed [10:0] COLS11   = 11'(SCREEN_COLUMNS);
  localparam logic signed [7:0]  PAGES8   = 8'(PAGES);

  logic signed [9:0]  origin_x_r, origin_y_r;
  logic [7:0]         width_r;
  logic [5:0]         page_total_r;
  mspb_mode_t         mode_r;
  logic [7:0]         col_cnt_r;
  logic [5:0]         page_cnt_r;
  logic signed [10:0] col_r;
  logic signed [7:0]  page_r;
  logic [2:0]         yoff_r;
  logic [15:0]        img16_r, msk16_r;
  logic [ADDR_W-1:0]  addr_lo_r, addr_hi_r;
  logic               rd_ok_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [7:0]         read_data_r;

  logic signed [11:0] bx, by, bw, bh;
  logic               cull;
  logic [8:0]         h_round;
  logic signed [7:0]  page_base, page_nxt, page_hi;
  logic signed [10:0] col_nxt;
  logic [15:0]        msk_src;
  logic               col_ok, lo_ok, hi_ok;
  logic [ADDR_W-1:0]  addr_lo, addr_hi;
  logic               host_ok;
  logic [ADDR_W-1:0]  host_a;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  assign bx      = 12'(pos_x);
  assign by      = 12'(pos_y);
  assign bw      = $signed({4'b0000, sprite_width});
  assign bh      = $signed({4'b0000, sprite_height});
  assign cull    = (bx + bw <= 12'sd0) || (bx >= COLS12) ||
                   (by + bh <= 12'sd0) || (by >= ROWS12) || (sprite_width == 8'd0);
  assign h_round = {1'b0, sprite_height} + 9'd7;

  assign page_base = 8'(origin_y_r >>> 3);
  assign page_nxt  = page_base + $signed({2'b00, page_cnt_r});
  assign col_nxt   = 11'(origin_x_r) + $signed({3'b000, col_cnt_r});
  assign msk_src   = (mode_r == MODE_MASK) ? {8'h00, mask_byte} : {8'h00, BYTE_ONES};

  assign page_hi = page_r + 8'sd1;
  assign col_ok  = (col_r >= 11'sd0) && (col_r < COLS11);
  assign lo_ok   = col_ok && (page_r >= 8'sd0) && (page_r < PAGES8);
  assign hi_ok   = col_ok && (yoff_r != 3'd0) && (page_hi >= 8'sd0) && (page_hi < PAGES8);
  assign addr_lo = ADDR_W'(page_r[PIDX_W-1:0]) * COLS_A + ADDR_W'(col_r[CIDX_W-1:0]);
  assign addr_hi = ADDR_W'(page_hi[PIDX_W-1:0]) * COLS_A + ADDR_W'(col_r[CIDX_W-1:0]);

  assign host_ok = CMP_W'(store_addr) < STORE_LIM;
  assign host_a  = ADDR_W'(store_addr);

  assign stat.active   = page_cnt_r < page_total_r;
  assign stat.lo_ok    = lo_ok;
  assign stat.hi_ok    = hi_ok;
  assign stat.clr_last = clr_cnt_r == CLR_LAST;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = 8'h00;
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.wr_host) begin
      ram_we    = host_ok;
      ram_waddr = host_a;
      ram_wdata = store_data;
    end else if (cmd.wr_lo) begin
      ram_we    = 1'b1;
      ram_waddr = addr_lo_r;
      ram_wdata = mspb_apply(mode_r, ram_rdata, img16_r[7:0], msk16_r[7:0]);
    end else if (cmd.wr_hi) begin
      ram_we    = 1'b1;
      ram_waddr = addr_hi_r;
      ram_wdata = mspb_apply(mode_r, ram_rdata, img16_r[15:8], msk16_r[15:8]);
    end
  end

  always_comb begin
    ram_re    = cmd.rd_host || cmd.rd_lo || cmd.rd_hi;
    ram_raddr = host_a;
    if (cmd.rd_lo) begin
      ram_raddr = addr_lo;
    end else if (cmd.rd_hi) begin
      ram_raddr = addr_hi_r;
    end
  end

  mspb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      width_r      <= '0;
      page_total_r <= '0;
      mode_r       <= MODE_OVER;
      col_cnt_r    <= '0;
      page_cnt_r   <= '0;
      clr_cnt_r    <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + ADDR_ONE;
      end
      if (cmd.begin_load) begin
        origin_x_r   <= pos_x;
        origin_y_r   <= pos_y;
        width_r      <= sprite_width;
        mode_r       <= blend_mode;
        page_total_r <= cull ? 6'd0 : h_round[8:3];
        col_cnt_r    <= '0;
        page_cnt_r   <= '0;
      end else if (cmd.byte_load) begin
        if (col_cnt_r + 8'd1 >= width_r) begin
          col_cnt_r  <= '0;
          page_cnt_r <= page_cnt_r + 6'd1;
        end else begin
          col_cnt_r <= col_cnt_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_load) begin
      col_r   <= col_nxt;
      page_r  <= page_nxt;
      yoff_r  <= origin_y_r[2:0];
      img16_r <= {8'h00, image_byte} << origin_y_r[2:0];
      msk16_r <= msk_src << origin_y_r[2:0];
    end
    if (cmd.rd_lo) begin
      addr_lo_r <= addr_lo;
      addr_hi_r <= addr_hi;
    end
    if (cmd.rd_host) begin
      rd_ok_r <= host_ok;
    end
    if (cmd.out_load) begin
      read_data_r <= rd_ok_r ? ram_rdata : 8'h00;
    end
  end

  assign read_data = read_data_r;

endmodule

### hdl/masked_sprite_blit_page_buffer_unit.sv
// Top level of the masked sprite blit page buffer: controller, datapath
// and channel wiring. Depends on mspb_pkg, mspb_if, mspb_ctrl, mspb_dpath.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        func, position, size, mode, bytes, addr
//   out_ch    out   valid/ready        read_data (one per read item)
//
// Begin, write and idle sprite-byte items are taken without leaving the idle
// state; a read item waits in the host read state for the result register to empty.
// A sprite byte steps through the low read, low write and high write states (no
// high write without a second page), as each write needs a registered read first.
// After reset a clearing pass writes zero to every store byte, one per cycle
// (1024 store bytes at 128 x 64), while in_ch.ready stays low.
// A held result stalls only the next read item.
`timescale 1ns / 1ps

module masked_sprite_blit_page_buffer_unit import mspb_pkg::*; #(
  parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mspb_in_if.sink    in_ch,
  mspb_out_if.source out_ch
);

  mspb_cmd_t  cmd;
  mspb_stat_t stat;
  logic       in_ready;
  logic       out_valid;

  mspb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mspb_dpath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .pos_x         (in_ch.pos_x),
    .pos_y         (in_ch.pos_y),
    .sprite_width  (in_ch.sprite_width),
    .sprite_height (in_ch.sprite_height),
    .blend_mode    (in_ch.blend_mode),
    .image_byte    (in_ch.image_byte),
    .mask_byte     (in_ch.mask_byte),
    .store_addr    (in_ch.store_addr),
    .store_data    (in_ch.store_data),
    .read_data     (out_ch.read_data)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.wr_host, cmd.wr_lo, cmd.wr_hi}))
    else $error("frame store write sources collide");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten while held");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("item taken before clearing pass");

  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_load |=> !in_ch.ready)
    else $error("item taken during read-modify-write");

endmodule

### test/tb_top.sv
// Testbench for masked_sprite_blit_page_buffer_unit: sprite blits, store reads and writes.
// A scoreboard class predicts the frame store and checks each read result in order.
// Depends on mspb_pkg, mspb_if and the RTL top level.
`timescale 1ns / 1ps

module tb_top import mspb_pkg::*; ();

  localparam int COLS         = SCREEN_COLUMNS_DEF;
  localparam int PAGES        = SCREEN_ROWS_DEF / PIX_PER_PAGE;
  localparam int STORE_BYTES  = COLS * PAGES;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    mspb_func_t        func;
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic [7:0]        sprite_width;
    logic [7:0]        sprite_height;
    mspb_mode_t        blend_mode;
    logic [7:0]        image_byte;
    logic [7:0]        mask_byte;
    logic [9:0]        store_addr;
    logic [7:0]        store_data;
  } blit_item_t;

  class frame_scoreboard;
    logic [7:0] frame_mem [STORE_BYTES];
    int         org_x;
    int         org_y;
    int         blit_cols;
    int         page_total;
    int         col_idx;
    int         page_idx;
    mspb_mode_t mode;
    logic [7:0] read_q [$];
    int         mismatches;
    int         reads_checked;

    function new();
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      org_x = 0;
      org_y = 0;
      blit_cols = 0;
      page_total = 0;
      col_idx = 0;
      page_idx = 0;
      mode = MODE_OVER;
      mismatches = 0;
      reads_checked = 0;
    endfunction

    function int pending();
      return read_q.size();
    endfunction

    function void merge_byte(int page, int col, logic [7:0] img, logic [7:0] msk);
      int idx;
      if (page < 0 || page >= PAGES) return;
      idx = page * COLS + col;
      case (mode)
        MODE_OR:    frame_mem[idx] = frame_mem[idx] | img;
        MODE_ERASE: frame_mem[idx] = frame_mem[idx] & ~img;
        default:    frame_mem[idx] = (frame_mem[idx] & ~msk) | img;
      endcase
    endfunction

    function void draw_sprite_byte(logic [7:0] img, logic [7:0] msk);
      int yoff;
      int page;
      int col;
      logic [15:0] img16;
      logic [15:0] msk16;
      if (page_idx >= page_total || blit_cols == 0) return;
      yoff = org_y & 7;
      page = (org_y - yoff) / 8 + page_idx;
      col = org_x + col_idx;
      img16 = {8'h00, img} << yoff;
      msk16 = {8'h00, (mode == MODE_MASK) ? msk : BYTE_ONES} << yoff;
      if (col >= 0 && col < COLS) begin
        merge_byte(page, col, img16[7:0], msk16[7:0]);
        if (yoff != 0) merge_byte(page + 1, col, img16[15:8], msk16[15:8]);
      end
      col_idx++;
      if (col_idx >= blit_cols) begin
        col_idx = 0;
        page_idx++;
      end
    endfunction

    function void note_item(blit_item_t it);
      int h;
      case (it.func)
        FUNC_BEGIN: begin
          org_x = int'(it.pos_x);
          org_y = int'(it.pos_y);
          blit_cols = int'(it.sprite_width);
          h = int'(it.sprite_height);
          mode = it.blend_mode;
          page_total = (h + 7) / 8;
          if (org_x + blit_cols <= 0 || org_x >= COLS || org_y + h <= 0 ||
              org_y >= SCREEN_ROWS_DEF || blit_cols == 0)
            page_total = 0;
          col_idx = 0;
          page_idx = 0;
        end
        FUNC_SPRITE: draw_sprite_byte(it.image_byte, it.mask_byte);
        FUNC_READ: read_q.push_back((it.store_addr < STORE_BYTES) ?
                                    frame_mem[it.store_addr] : 8'h00);
        default: begin
          if (it.store_addr < STORE_BYTES) frame_mem[it.store_addr] = it.store_data;
        end
      endcase
    endfunction

    function void check_read(logic [7:0] got);
      logic [7:0] want;
      if (read_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: read_data %02h arrived with no read pending", $time, got);
        return;
      end
      want = read_q.pop_front();
      reads_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: read_data expected %02h actual %02h", $time, want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mspb_in_if  in_ch ();
  mspb_out_if out_ch ();

  masked_sprite_blit_page_buffer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_scoreboard sb = new();
  int send_idle_pct = 28;
  int recv_idle_pct = 61;
  int hold_req = 0;
  int holds_done = 0;
  int items_sent = 0;
  int func_count [4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_read(out_ch.read_data);
  end

  function automatic blit_item_t random_item();
    blit_item_t it;
    it.func = mspb_func_t'($urandom_range(3));
    it.pos_x = 10'($urandom);
    it.pos_y = 10'($urandom);
    it.sprite_width = 8'($urandom);
    it.sprite_height = 8'($urandom);
    it.blend_mode = mspb_mode_t'($urandom_range(3));
    it.image_byte = 8'($urandom);
    it.mask_byte = 8'($urandom);
    it.store_addr = 10'($urandom);
    it.store_data = 8'($urandom);
    return it;
  endfunction

  // drive on the falling edge, take the handshake on the rising edge
  task automatic send_item(blit_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func = it.func;
    in_ch.pos_x = it.pos_x;
    in_ch.pos_y = it.pos_y;
    in_ch.sprite_width = it.sprite_width;
    in_ch.sprite_height = it.sprite_height;
    in_ch.blend_mode = it.blend_mode;
    in_ch.image_byte = it.image_byte;
    in_ch.mask_byte = it.mask_byte;
    in_ch.store_addr = it.store_addr;
    in_ch.store_data = it.store_data;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    items_sent++;
    func_count[it.func]++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_begin(int x, int y, int w, int h, mspb_mode_t m);
    blit_item_t it;
    it = random_item();
    it.func = FUNC_BEGIN;
    it.pos_x = x[9:0];
    it.pos_y = y[9:0];
    it.sprite_width = w[7:0];
    it.sprite_height = h[7:0];
    it.blend_mode = m;
    send_item(it);
  endtask

  task automatic send_sprite(logic [7:0] img, logic [7:0] msk);
    blit_item_t it;
    it = random_item();
    it.func = FUNC_SPRITE;
    it.image_byte = img;
    it.mask_byte = msk;
    send_item(it);
  endtask

  task automatic send_read(int addr);
    blit_item_t it;
    it = random_item();
    it.func = FUNC_READ;
    it.store_addr = addr[9:0];
    send_item(it);
  endtask

  task automatic send_write(int addr, logic [7:0] data);
    blit_item_t it;
    it = random_item();
    it.func = FUNC_WRITE;
    it.store_addr = addr[9:0];
    it.store_data = data;
    send_item(it);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // pick a store byte inside or next to the sprite's footprint
  function automatic int footprint_addr(int x, int y, int w, int h);
    int col;
    int page;
    col = x + $urandom_range(w - 1);
    page = (y - (y & 7)) / 8 + $urandom_range((h + 7) / 8);
    if (col < 0) col = 0;
    if (col >= COLS) col = COLS - 1;
    if (page < 0) page = 0;
    if (page >= PAGES) page = PAGES - 1;
    return page * COLS + col;
  endfunction

  task automatic random_blit();
    int x;
    int y;
    int w;
    int h;
    int nbytes;
    x = $urandom_range(140);
    x -= 10;
    y = $urandom_range(80);
    y -= 12;
    w = ($urandom_range(9) == 0) ? $urandom_range(48, 1) : $urandom_range(12, 1);
    h = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(20, 1);
    send_begin(x, y, w, h, mspb_mode_t'($urandom_range(3)));
    nbytes = w * ((h + 7) / 8);
    if ($urandom_range(9) == 0) nbytes = $urandom_range(nbytes);
    repeat (nbytes) send_sprite(8'($urandom), 8'($urandom));
    repeat ($urandom_range(3, 1)) send_read(footprint_addr(x, y, w, h));
  endtask

  task automatic random_phase(int item_goal);
    int pick;
    while (items_sent < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 55) random_blit();
      else if (pick < 75) send_read($urandom_range(STORE_BYTES - 1));
      else if (pick < 88) send_write($urandom_range(STORE_BYTES - 1), 8'($urandom));
      else send_item(random_item());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_BEGIN;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.sprite_width = '0;
    in_ch.sprite_height = '0;
    in_ch.blend_mode = MODE_OVER;
    in_ch.image_byte = '0;
    in_ch.mask_byte = '0;
    in_ch.store_addr = '0;
    in_ch.store_data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    send_read(0);
    send_read(STORE_BYTES - 1);
    send_write(0, 8'hFF);
    send_write(STORE_BYTES - 1, 8'h5A);
    send_sprite(8'hFF, 8'hFF);
    send_begin(-512, 0, 255, 8, MODE_OVER);
    send_sprite(8'hFF, 8'hFF);
    send_begin(511, 0, 8, 8, MODE_OR);
    send_begin(0, -512, 8, 255, MODE_ERASE);
    send_begin(0, 511, 8, 8, MODE_MASK);
    send_begin(0, 0, 0, 8, MODE_OR);
    send_sprite(8'hFF, 8'hFF);
    send_begin(0, 0, 8, 0, MODE_OR);
    send_begin(-1, -3, 2, 8, MODE_OVER);
    send_sprite(8'hFF, 8'h00);
    send_sprite(8'h81, 8'h00);
    send_begin(127, 60, 2, 8, MODE_MASK);
    send_sprite(8'h3C, 8'h00);
    send_sprite(8'hFF, 8'hFF);
    send_begin(10, 8, 1, 8, MODE_OR);
    send_sprite(8'h0F, 8'h00);
    send_begin(10, 8, 1, 8, MODE_ERASE);
    send_sprite(8'h03, 8'h00);
    send_read(0);
    send_read(STORE_BYTES - 1);
    send_read(COLS + 10);

    random_phase(300);
    wait_drained();
    send_idle_pct = 61;
    recv_idle_pct = 28;
    random_phase(580);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // hold results back so the block backs up on reads
    hold_req++;
    repeat (12) send_read($urandom_range(STORE_BYTES - 1));
    wait_drained();
    random_phase(850);

    in_ch.valid = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run: %0d items (%0d begin, %0d sprite byte, %0d read, %0d write)",
             items_sent, func_count[FUNC_BEGIN], func_count[FUNC_SPRITE],
             func_count[FUNC_READ], func_count[FUNC_WRITE]);
    $display("run: %0d store bytes checked, %0d mismatches, %0d reads outstanding",
             sb.reads_checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
